@@ hdl/nge_pkg.sv @@
// Shared constants and types of the next-greater-element engine.
package nge_pkg;

	// Fixed widths of the channel fields.
	localparam int SAMPLE_BITS   = 32;
	localparam int POSITION_BITS = 10;
	localparam int ANSWER_BITS   = 32;

	// Default sizing of the engine.
	localparam int STACK_DEPTH_DEF = 32;
	localparam int MAX_LENGTH_DEF  = 1024;
	localparam int VALUE_BITS_DEF  = 32;

	// Result outcome codes.
	typedef enum logic [1:0] {
		OUTCOME_FOUND   = 2'd0,
		OUTCOME_NONE    = 2'd1,
		OUTCOME_EVICTED = 2'd2
	} outcome_t;

endpackage

@@ hdl/nge_ifs.sv @@
// Stream and configuration channel interfaces of the next-greater-element engine.

// Input item channel: one signed sample per transfer.
interface nge_in_if;
	import nge_pkg::*;
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample_value;
	logic                          end_of_sequence;

	modport source (output valid, sample_value, end_of_sequence, input ready);
	modport sink   (input valid, sample_value, end_of_sequence, output ready);
endinterface

// Result channel: one answered position per transfer.
interface nge_out_if;
	import nge_pkg::*;
	logic                          valid;
	logic                          ready;
	logic [POSITION_BITS-1:0]      position;
	logic signed [ANSWER_BITS-1:0] answer_value;
	outcome_t                      outcome;
	logic                          last_of_run;

	modport source (output valid, position, answer_value, outcome, last_of_run, input ready);
	modport sink   (input valid, position, answer_value, outcome, last_of_run, output ready);
endinterface

// Configuration write channel for the compare mode register.
interface nge_cfg_if;
	logic valid;
	logic ready;
	logic compare_mode;

	modport source (output valid, compare_mode, input ready);
	modport sink   (input valid, compare_mode, output ready);
endinterface

@@ hdl/next_greater_element_engine_unit.sv @@
// Next-greater / next-smaller element engine built around a stack memory.
//
// Usage: samples enter on sample_in, one per transfer. Each sample pops every
// pending entry it answers (strictly greater in mode 0, strictly smaller in
// mode 1) and is then pushed. A sample flagged end_of_sequence flushes every
// pending entry as not found, newest first, and restarts positions at zero.
// When the stack is full and nothing was popped, the oldest entry is evicted.
// Results leave on result_out; last_of_run marks the final result of an item.
// The cfg channel writes compare_mode; write it only while the engine is idle.
//
// The input is ready again only once the engine has finished the current item,
// including its pops, any eviction and any end-of-sequence flush. The single read
// port of the stack memory sets the pace: one entry is read and examined per cycle
// while the staging register can take a result.
// Reset: the stack count, position counter and compare mode clear to zero; the
// stack memory itself needs no clearing. If result_out stalls, the engine holds
// one finished result in the output register and one in a staging register,
// then waits; no result is dropped.
module next_greater_element_engine_unit #(
	parameter int STACK_DEPTH = nge_pkg::STACK_DEPTH_DEF,
	parameter int MAX_LENGTH  = nge_pkg::MAX_LENGTH_DEF,
	parameter int VALUE_BITS  = nge_pkg::VALUE_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	nge_cfg_if.sink   cfg,
	nge_in_if.sink    sample_in,
	nge_out_if.source result_out
);
	import nge_pkg::*;

	localparam int IDX_BITS = $clog2(STACK_DEPTH);
	localparam int CNT_BITS = $clog2(STACK_DEPTH + 1);
	localparam int SUM_BITS = CNT_BITS + 1;
	localparam int POS_BITS = $clog2(MAX_LENGTH);

	typedef logic signed [VALUE_BITS-1:0] val_t;

	typedef struct packed {
		logic [POS_BITS-1:0]   pos;
		logic [VALUE_BITS-1:0] val;
	} entry_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CMP,
		S_EVICT,
		S_PUSH,
		S_FLUSH,
		S_DONE
	} state_t;

	// Circular index: base plus offset, wrapped at the stack depth.
	function automatic logic [IDX_BITS-1:0] wrap_idx(input logic [IDX_BITS-1:0] b,
	                                                 input logic [CNT_BITS-1:0] off);
		logic [SUM_BITS-1:0] s;
		s = SUM_BITS'(b) + SUM_BITS'(off);
		if (s >= SUM_BITS'(STACK_DEPTH)) begin
			s = s - SUM_BITS'(STACK_DEPTH);
		end
		return s[IDX_BITS-1:0];
	endfunction

	// Control registers.
	state_t              state_q;
	logic [IDX_BITS-1:0] base_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic [POS_BITS-1:0] pos_q;
	logic                mode_q;
	logic                stg_vld_q;
	logic                out_vld_q;

	// Payload registers.
	val_t                   cur_val_q;
	logic                   last_q;
	entry_t                 rd_data_q;
	logic [POS_BITS-1:0]    stg_pos_q;
	logic [ANSWER_BITS-1:0] stg_ans_q;
	outcome_t               stg_outc_q;
	logic [POSITION_BITS-1:0] out_pos_q;
	logic [ANSWER_BITS-1:0] out_ans_q;
	outcome_t               out_outc_q;
	logic                   out_last_q;

	// Stack memory.
	entry_t stack_mem_q [STACK_DEPTH];

	// Next-state and memory control.
	state_t                 state_d;
	logic [IDX_BITS-1:0]    base_d;
	logic [CNT_BITS-1:0]    cnt_d;
	logic [POS_BITS-1:0]    pos_d;
	logic                   rd_en;
	logic [IDX_BITS-1:0]    rd_addr;
	logic                   wr_en;
	logic [IDX_BITS-1:0]    wr_addr;
	logic                   emit;
	logic [POS_BITS-1:0]    emit_pos;
	logic [ANSWER_BITS-1:0] emit_ans;
	outcome_t               emit_outc;
	logic                   finish;
	logic                   accept;
	logic                   out_free;
	logic                   can_emit;
	logic                   top_hit;
	logic                   stack_full;
	logic [POS_BITS-1:0]    pos_inc;

	assign sample_in.ready = (state_q == S_IDLE);
	assign cfg.ready       = 1'b1;
	assign accept          = sample_in.valid && sample_in.ready;

	// The staging register may take a new result if it is empty or can move on.
	assign out_free   = !out_vld_q || result_out.ready;
	assign can_emit   = !stg_vld_q || out_free;
	assign stack_full = (cnt_q == CNT_BITS'(STACK_DEPTH));
	assign pos_inc    = (pos_q == POS_BITS'(MAX_LENGTH - 1)) ? '0 : pos_q + POS_BITS'(1);

	// Compare the new sample against the entry read from the top of the stack.
	always_comb begin
		if (mode_q) begin
			top_hit = $signed(cur_val_q) < $signed(rd_data_q.val);
		end else begin
			top_hit = $signed(rd_data_q.val) < $signed(cur_val_q);
		end
	end

	// Sequencer: pop loop, eviction, push and flush, at most one memory access per cycle.
	always_comb begin
		state_d   = state_q;
		base_d    = base_q;
		cnt_d     = cnt_q;
		pos_d     = pos_q;
		rd_en     = 1'b0;
		rd_addr   = '0;
		wr_en     = 1'b0;
		wr_addr   = wrap_idx(base_q, cnt_q);
		emit      = 1'b0;
		emit_pos  = rd_data_q.pos;
		emit_ans  = '1;
		emit_outc = OUTCOME_FOUND;
		finish    = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (cnt_q == '0) begin
						state_d = S_PUSH;
					end else begin
						rd_en   = 1'b1;
						rd_addr = wrap_idx(base_q, cnt_q - CNT_BITS'(1));
						state_d = S_CMP;
					end
				end
			end
			S_CMP: begin
				if (top_hit) begin
					if (can_emit) begin
						emit     = 1'b1;
						emit_ans = ANSWER_BITS'($signed(cur_val_q));
						cnt_d    = cnt_q - CNT_BITS'(1);
						if (cnt_q > CNT_BITS'(1)) begin
							rd_en   = 1'b1;
							rd_addr = wrap_idx(base_q, cnt_q - CNT_BITS'(2));
						end else begin
							state_d = S_PUSH;
						end
					end
				end else if (stack_full) begin
					rd_en   = 1'b1;
					rd_addr = base_q;
					state_d = S_EVICT;
				end else begin
					state_d = S_PUSH;
				end
			end
			S_EVICT: begin
				if (can_emit) begin
					emit      = 1'b1;
					emit_outc = OUTCOME_EVICTED;
					base_d    = wrap_idx(base_q, CNT_BITS'(1));
					cnt_d     = cnt_q - CNT_BITS'(1);
					state_d   = S_PUSH;
				end
			end
			S_PUSH: begin
				if (!last_q) begin
					wr_en   = 1'b1;
					cnt_d   = cnt_q + CNT_BITS'(1);
					pos_d   = pos_inc;
					state_d = S_DONE;
				end else if (can_emit) begin
					// The new entry is the top of the flush; it needs no write.
					emit      = 1'b1;
					emit_pos  = pos_q;
					emit_outc = OUTCOME_NONE;
					pos_d     = '0;
					if (cnt_q != '0) begin
						rd_en   = 1'b1;
						rd_addr = wrap_idx(base_q, cnt_q - CNT_BITS'(1));
						state_d = S_FLUSH;
					end else begin
						state_d = S_DONE;
					end
				end
			end
			S_FLUSH: begin
				if (can_emit) begin
					emit      = 1'b1;
					emit_outc = OUTCOME_NONE;
					cnt_d     = cnt_q - CNT_BITS'(1);
					if (cnt_q > CNT_BITS'(1)) begin
						rd_en   = 1'b1;
						rd_addr = wrap_idx(base_q, cnt_q - CNT_BITS'(2));
					end else begin
						state_d = S_DONE;
					end
				end
			end
			S_DONE: begin
				if (!stg_vld_q) begin
					state_d = S_IDLE;
				end else if (out_free) begin
					finish  = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State, counters, mode and valid flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			base_q    <= '0;
			cnt_q     <= '0;
			pos_q     <= '0;
			mode_q    <= 1'b0;
			stg_vld_q <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			base_q  <= base_d;
			cnt_q   <= cnt_d;
			pos_q   <= pos_d;
			if (cfg.valid) begin
				mode_q <= cfg.compare_mode;
			end
			if (emit) begin
				stg_vld_q <= 1'b1;
			end else if (finish) begin
				stg_vld_q <= 1'b0;
			end
			if ((emit && stg_vld_q) || finish) begin
				out_vld_q <= 1'b1;
			end else if (result_out.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// Item, staging and output payloads.
	always_ff @(posedge clk) begin
		if (accept) begin
			cur_val_q <= val_t'(sample_in.sample_value);
			last_q    <= sample_in.end_of_sequence;
		end
		if (emit) begin
			stg_pos_q  <= emit_pos;
			stg_ans_q  <= emit_ans;
			stg_outc_q <= emit_outc;
		end
		if ((emit && stg_vld_q) || finish) begin
			out_pos_q  <= POSITION_BITS'(stg_pos_q);
			out_ans_q  <= stg_ans_q;
			out_outc_q <= stg_outc_q;
			out_last_q <= finish;
		end
	end

	// Stack memory: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			stack_mem_q[wr_addr] <= '{pos: pos_q, val: cur_val_q};
		end
		if (rd_en) begin
			rd_data_q <= stack_mem_q[rd_addr];
		end
	end

	assign result_out.valid        = out_vld_q;
	assign result_out.position     = out_pos_q;
	assign result_out.answer_value = out_ans_q;
	assign result_out.outcome      = out_outc_q;
	assign result_out.last_of_run  = out_last_q;

	// The stack never holds more entries than it has room for.
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_BITS'(STACK_DEPTH))
		else $error("stack count exceeds depth");

	// Eviction happens only on a full stack.
	a_evict_full: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EVICT) |-> stack_full)
		else $error("eviction without a full stack");

	// An end-of-sequence item leaves the stack empty.
	a_flush_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && last_q) |-> (cnt_q == '0))
		else $error("stack not empty after flush");

	// A staged result moves out only into a free output register.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		((emit && stg_vld_q) || finish) |-> out_free)
		else $error("output register overwritten while stalled");

	// Closing an item leaves nothing staged for the next one.
	a_finish_clears: assert property (@(posedge clk) disable iff (!arst_n)
		finish |=> (!stg_vld_q && state_q == S_IDLE))
		else $error("staged result left behind at end of item");

endmodule
